// File: hdl/cpde_pkg.sv
// shared types, constants and saturating arithmetic for the chebyshev
// polynomial and derivative evaluator; no dependencies
package cpde_pkg;

   localparam int DEGREE_W = 5;
   localparam int POINT_W  = 32;
   localparam int WORD_W   = 64;
   localparam int EXT_W    = WORD_W + 3;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [EXT_W-1:0]  ext_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // which of the four recurrences a pass belongs to
   typedef enum logic [1:0] {
      TERM_VAL,
      TERM_D1,
      TERM_D2,
      TERM_D3
   } term_type;

   // one multiplier pass: low or high half of a 64-bit operand
   typedef struct packed {
      logic     valid;
      term_type term;
      logic     half;
   } issue_type;

   // tag travelling with a finished product
   typedef struct packed {
      logic     valid;
      term_type term;
   } tag_type;

   // clamp a widened value to the signed 64-bit range
   function automatic word_type sat_word(input ext_type v);
      word_type r;
      if (v[EXT_W-1:WORD_W-1] == '0 || v[EXT_W-1:WORD_W-1] == '1) begin
         r = v[WORD_W-1:0];
      end else if (v[EXT_W-1]) begin
         r = WORD_MIN;
      end else begin
         r = WORD_MAX;
      end
      return r;
   endfunction

   function automatic ext_type widen(input word_type v);
      return {{(EXT_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      return sat_word(widen(a) + widen(b));
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      return sat_word(widen(a) - widen(b));
   endfunction

   // saturated 0/2/4/6 times the lower-order term, by recurrence
   function automatic word_type scale_term(input word_type v, input term_type term);
      ext_type  e;
      word_type r;
      e = widen(v);
      unique case (term)
         TERM_VAL: r = '0;
         TERM_D1:  r = sat_word(e <<< 1);
         TERM_D2:  r = sat_word(e <<< 2);
         TERM_D3:  r = sat_word((e <<< 2) + (e <<< 1));
         default:  r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/chebyshev_poly_deriv_eval_core.sv
// chebyshev first-kind polynomial T_n(x) with first three derivatives,
// forward recurrence on one shared multiplier; uses cpde_pkg, cpde_mul_unit
//
//   channel | direction | fields                                       | handshake
//   req     | in        | degree[4:0], point[31:0] (Q2.30)             | req_valid/req_ready
//   rsp     | out       | value, first_deriv, second_deriv, third_deriv | rsp_valid/rsp_ready
//
// degree 0 or 1: result is ready the cycle after the item is taken
// degree n >= 2: each recurrence step runs eight passes of the 33x33 multiplier (two
//   halves of four 64-bit operands), then drains through product, result, acc and nxt regs
// one item at a time: req_ready is low from acceptance until the result is taken
// a stalled result holds its registers; synchronous reset returns to idle
module chebyshev_poly_deriv_eval_core import cpde_pkg::*; #(
   parameter int MAX_DEGREE = 31,
   parameter int FRAC_BITS  = 30
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [DEGREE_W-1:0]        req_degree,
   input  logic signed [POINT_W-1:0]  req_point,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_value,
   output logic signed [WORD_W-1:0]   rsp_first_deriv,
   output logic signed [WORD_W-1:0]   rsp_second_deriv,
   output logic signed [WORD_W-1:0]   rsp_third_deriv
);

   localparam logic [DEGREE_W-1:0] DEGREE_LIMIT = DEGREE_W'(MAX_DEGREE);
   localparam word_type            ONE_WORD     = word_type'(64'sd1 <<< FRAC_BITS);
   localparam logic [3:0]          PHASE_ISSUE  = 4'd8;
   localparam logic [3:0]          PHASE_LAST   = 4'd11;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   state_type                   state_ff;
   logic [3:0]                  phase_ff;
   logic [DEGREE_W-1:0]         degree_ff;
   logic [DEGREE_W-1:0]         k_ff;
   logic signed [POINT_W-1:0]   x_ff;
   logic [DEGREE_W-1:0]         degree_in;

   // degree k-1 (cur), k-2 (prv) and the step being built (nxt)
   word_type cur_val_ff, cur_d1_ff, cur_d2_ff, cur_d3_ff;
   word_type prv_val_ff, prv_d1_ff, prv_d2_ff, prv_d3_ff;
   word_type nxt_val_ff, nxt_d1_ff, nxt_d2_ff, nxt_d3_ff;

   issue_type issue;
   word_type  operand;
   tag_type   q_tag;
   word_type  q_word;
   word_type  lower_word;
   word_type  acc_in;
   word_type  acc_ff;
   tag_type   acc_tag_ff;
   word_type  prv_word;
   word_type  nxt_in;

   assign degree_in = (req_degree > DEGREE_LIMIT) ? DEGREE_LIMIT : req_degree;

   // multiplier pass schedule for the current step
   always_comb begin
      issue.valid = (state_ff == S_RUN) && (phase_ff < PHASE_ISSUE);
      issue.term  = term_type'(phase_ff[2:1]);
      issue.half  = phase_ff[0];
   end

   // operand for the pass: the degree k-1 term of its own recurrence
   always_comb begin
      unique case (issue.term)
         TERM_VAL: operand = cur_val_ff;
         TERM_D1:  operand = cur_d1_ff;
         TERM_D2:  operand = cur_d2_ff;
         TERM_D3:  operand = cur_d3_ff;
         default:  operand = cur_val_ff;
      endcase
   end

   cpde_mul_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .point   (x_ff),
      .issue   (issue),
      .operand (operand),
      .q_tag   (q_tag),
      .q_word  (q_word)
   );

   // lower-order term feeding the scaled contribution
   always_comb begin
      unique case (q_tag.term)
         TERM_VAL: lower_word = '0;
         TERM_D1:  lower_word = cur_val_ff;
         TERM_D2:  lower_word = cur_d1_ff;
         TERM_D3:  lower_word = cur_d2_ff;
         default:  lower_word = '0;
      endcase
      acc_in = sat_add(scale_term(lower_word, q_tag.term), q_word);
   end

   // subtract the degree k-2 term
   always_comb begin
      unique case (acc_tag_ff.term)
         TERM_VAL: prv_word = prv_val_ff;
         TERM_D1:  prv_word = prv_d1_ff;
         TERM_D2:  prv_word = prv_d2_ff;
         TERM_D3:  prv_word = prv_d3_ff;
         default:  prv_word = prv_val_ff;
      endcase
      nxt_in = sat_sub(acc_ff, prv_word);
   end

   // sequencer and recurrence registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= '0;
         acc_tag_ff <= '0;
      end else begin
         acc_tag_ff <= q_tag;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  phase_ff <= '0;
                  state_ff <= (degree_in < DEGREE_W'(2)) ? S_DONE : S_RUN;
               end
            end
            S_RUN: begin
               if (phase_ff == PHASE_LAST) begin
                  phase_ff <= '0;
                  if (k_ff + DEGREE_W'(1) == degree_ff) begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  phase_ff <= phase_ff + 4'd1;
               end
            end
            S_DONE: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end

      if (q_tag.valid) begin
         acc_ff <= acc_in;
      end

      if (acc_tag_ff.valid) begin
         unique case (acc_tag_ff.term)
            TERM_VAL: nxt_val_ff <= nxt_in;
            TERM_D1:  nxt_d1_ff  <= nxt_in;
            TERM_D2:  nxt_d2_ff  <= nxt_in;
            TERM_D3:  nxt_d3_ff  <= nxt_in;
            default:  nxt_val_ff <= nxt_in;
         endcase
      end

      // load seeds on a new item
      if (state_ff == S_IDLE && req_valid) begin
         degree_ff  <= degree_in;
         k_ff       <= DEGREE_W'(1);
         x_ff       <= req_point;
         prv_val_ff <= ONE_WORD;
         prv_d1_ff  <= '0;
         prv_d2_ff  <= '0;
         prv_d3_ff  <= '0;
         cur_d2_ff  <= '0;
         cur_d3_ff  <= '0;
         if (degree_in == '0) begin
            cur_val_ff <= ONE_WORD;
            cur_d1_ff  <= '0;
         end else begin
            cur_val_ff <= {{(WORD_W-POINT_W){req_point[POINT_W-1]}}, req_point};
            cur_d1_ff  <= ONE_WORD;
         end
      end

      // advance one degree
      if (state_ff == S_RUN && phase_ff == PHASE_LAST) begin
         k_ff       <= k_ff + DEGREE_W'(1);
         prv_val_ff <= cur_val_ff;
         prv_d1_ff  <= cur_d1_ff;
         prv_d2_ff  <= cur_d2_ff;
         prv_d3_ff  <= cur_d3_ff;
         cur_val_ff <= nxt_val_ff;
         cur_d1_ff  <= nxt_d1_ff;
         cur_d2_ff  <= nxt_d2_ff;
         cur_d3_ff  <= nxt_d3_ff;
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_DONE);
   assign rsp_value        = cur_val_ff;
   assign rsp_first_deriv  = cur_d1_ff;
   assign rsp_second_deriv = cur_d2_ff;
   assign rsp_third_deriv  = cur_d3_ff;

endmodule

// File: hdl/cpde_mul_unit.sv
// shared product unit: floor(2*x*v / 2^FRAC_BITS) saturated to 64 bits,
// built from two passes of one 33x33 signed multiplier; uses cpde_pkg
module cpde_mul_unit import cpde_pkg::*; #(
   parameter int FRAC_BITS = 30
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [POINT_W-1:0] point,
   input  issue_type                 issue,
   input  word_type                  operand,
   output tag_type                   q_tag,
   output word_type                  q_word
);

   localparam int HALF_W  = 32;
   localparam int MUL_W   = 2 * (HALF_W + 1);
   localparam int PART_W  = MUL_W - 1;
   localparam int FULL_W  = PART_W + HALF_W;
   localparam int SHIFT   = FRAC_BITS - 1;

   logic signed [HALF_W:0]   opnd_half;
   logic signed [MUL_W-1:0]  prod_full;
   logic signed [PART_W-1:0] mul_ff;
   issue_type                mtag_ff;
   logic signed [PART_W-1:0] lo_ff;
   logic signed [FULL_W-1:0] full;
   logic signed [FULL_W-1:0] shifted;
   word_type                 q_in;
   word_type                 q_ff;
   tag_type                  qtag_ff;

   // low half is unsigned, high half carries the sign
   assign opnd_half = issue.half ? {operand[WORD_W-1], operand[WORD_W-1:HALF_W]}
                                 : {1'b0, operand[HALF_W-1:0]};
   assign prod_full = $signed({point[POINT_W-1], point}) * opnd_half;

   // recombine halves, floor shift, clamp
   always_comb begin
      full    = ({{HALF_W{mul_ff[PART_W-1]}}, mul_ff} <<< HALF_W)
              + {{HALF_W{lo_ff[PART_W-1]}}, lo_ff};
      shifted = full >>> SHIFT;
      if (shifted[FULL_W-1:WORD_W-1] == '0 || shifted[FULL_W-1:WORD_W-1] == '1) begin
         q_in = shifted[WORD_W-1:0];
      end else if (shifted[FULL_W-1]) begin
         q_in = WORD_MIN;
      end else begin
         q_in = WORD_MAX;
      end
   end

   // multiplier register, low-half hold, result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mtag_ff <= '0;
         qtag_ff <= '0;
      end else begin
         mtag_ff       <= issue;
         qtag_ff.valid <= mtag_ff.valid && mtag_ff.half;
         qtag_ff.term  <= mtag_ff.term;
      end
      mul_ff <= prod_full[PART_W-1:0];
      if (mtag_ff.valid && !mtag_ff.half) begin
         lo_ff <= mul_ff;
      end
      if (mtag_ff.valid && mtag_ff.half) begin
         q_ff <= q_in;
      end
   end

   assign q_tag  = qtag_ff;
   assign q_word = q_ff;

endmodule
